FILE: sv/dcm_pkg.sv
package dcm_pkg;

  // Fixed-point geometry: positions in units of 2^-23 pixel.
  localparam int FRAC_BITS = 23;
  localparam int POS_W     = 33;  // pixel (10b) plus fraction, and radius up to 512 px
  localparam int SQ_W      = 2 * POS_W;

  localparam int MAX_MASK_SIZE = 1024;

  // R2 sequence multipliers
  localparam logic [31:0] PHI_X = 32'd3242174889;
  localparam logic [31:0] PHI_Y = 32'd2447445413;

  // One item travelling down the chain
  typedef struct packed {
    logic       valid;
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] count;
  } dcm_item_t;

  // Shape geometry broadcast to every cell
  typedef struct packed {
    logic [POS_W-1:0] r_out;
    logic [SQ_W-1:0]  out_sq;
    logic [SQ_W-1:0]  in_sq;
    logic             ring;
  } dcm_geom_t;

  // Top 23 bits of (k * phi) mod 2^32
  function automatic logic [FRAC_BITS-1:0] sample_offset(input logic [7:0] k,
                                                         input logic [31:0] phi);
    logic [31:0] v;
    v = 32'(k) * phi;
    return v[31:32-FRAC_BITS];
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic [POS_W-1:0] a);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

endpackage

FILE: sv/dcm_cell.sv
// One sample point: distance, square, compare-and-count over three stages.
module dcm_cell import dcm_pkg::*; #(
  parameter int K = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  dcm_geom_t geom,
  input  dcm_item_t item_in,
  output dcm_item_t item_out
);

  localparam logic [FRAC_BITS-1:0] OFF_X = sample_offset(8'(K), PHI_X);
  localparam logic [FRAC_BITS-1:0] OFF_Y = sample_offset(8'(K), PHI_Y);

  dcm_item_t        s1, s2, s3;
  logic [POS_W-1:0] dx1, dy1;
  logic [SQ_W-1:0]  sqx2, sqy2;

  logic [POS_W-1:0] ox, oy;
  logic [SQ_W:0]    dist_sq;
  logic             hit;

  assign ox = {item_in.px, {FRAC_BITS{1'b0}}} + {{(POS_W-FRAC_BITS){1'b0}}, OFF_X};
  assign oy = {item_in.py, {FRAC_BITS{1'b0}}} + {{(POS_W-FRAC_BITS){1'b0}}, OFF_Y};

  assign dist_sq = {1'b0, sqx2} + {1'b0, sqy2};
  assign hit     = (dist_sq <= {1'b0, geom.out_sq}) &&
                   (!geom.ring || ({1'b0, geom.in_sq} <= dist_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= item_in.valid;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.px    <= item_in.px;
      s1.py    <= item_in.py;
      s1.count <= item_in.count;
      dx1      <= abs_diff(geom.r_out, ox);
      dy1      <= abs_diff(geom.r_out, oy);

      s2.px    <= s1.px;
      s2.py    <= s1.py;
      s2.count <= s1.count;
      sqx2     <= square(dx1);
      sqy2     <= square(dy1);

      s3.px    <= s2.px;
      s3.py    <= s2.py;
      s3.count <= s2.count + {7'b0, hit};
    end
  end

  assign item_out = s3;

endmodule

FILE: sv/dcm_out_buf.sv
// Two-entry result buffer; the chain advances while it has room.
module dcm_out_buf import dcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  logic [7:0] mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign room     = !fill[1];
  assign m_tvalid = (fill != 2'd0);
  assign m_tdata  = mem[rd_ptr];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

FILE: sv/disk_ring_coverage_mask.sv
// Anti-aliased coverage of one pixel of a square disk or ring mask.
// s_* channel: one pixel item per handshake (tdata = pixel_x, pixel_y).
// m_* channel: one coverage item per pixel, in input order, 0..SAMPLE_COUNT.
// cfg_* channel: register writes, always ready. Index 0 = mask_size,
//   index 1 = shape_mode; other indexes are dropped. Write only while idle.
// Structure: a chain of SAMPLE_COUNT cells that differ only in their R2 sample
//   point. Each cell takes three stages (distance, square, compare/count)
//   and hands the item and its running count to the next cell.
// Path: an accepted item passes every cell in turn, then enters the buffer.
// Throughput: one item per cycle while the result buffer has room; every cell stage holds a different item.
// Stall: results collect in a two-entry buffer; the whole chain freezes
//   (and s_tready drops) only when that buffer is full. One result may
//   wait at the output while new items are still taken.
// Reset: clears all stage valids and the buffer; mask_size returns to 16,
//   shape_mode to filled disk. Squared radii are registered and follow a
//   register write in the cycle after it, well inside the first cell's pipeline.
module disk_ring_coverage_mask import dcm_pkg::*; #(
  parameter int SAMPLE_COUNT = 255
) (
  input  logic        clk,
  input  logic        rst,
  // pixel items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
  // coverage items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] coverage
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [7:0] REG_MASK_SIZE  = 8'd0;
  localparam logic [7:0] REG_SHAPE_MODE = 8'd1;

  localparam logic [10:0]      SIZE_LIMIT = 11'(MAX_MASK_SIZE);
  localparam logic [POS_W-1:0] ONE_PIXEL  = POS_W'(1) << FRAC_BITS;

  logic [10:0]      mask_size;
  logic             shape_mode;
  logic [10:0]      size_c;
  logic [POS_W-1:0] r_out, r_in;
  logic [SQ_W-1:0]  out_sq, in_sq;
  dcm_geom_t        geom;

  dcm_item_t link [SAMPLE_COUNT+1];
  logic      en;

  // ---- configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_size  <= 11'd16;
      shape_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MASK_SIZE:  mask_size  <= cfg_data;
        REG_SHAPE_MODE: shape_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- radii: outer = size/2 px, inner = |outer - 1 px|
  assign size_c = (mask_size > SIZE_LIMIT) ? SIZE_LIMIT : mask_size;
  assign r_out  = {size_c, {(FRAC_BITS-1){1'b0}}};
  assign r_in   = abs_diff(r_out, ONE_PIXEL);

  always_ff @(posedge clk) begin
    out_sq <= square(r_out);
    in_sq  <= square(r_in);
  end

  assign geom.r_out  = r_out;
  assign geom.out_sq = out_sq;
  assign geom.in_sq  = in_sq;
  assign geom.ring   = shape_mode;

  // ---- sample chain
  assign s_tready    = en;
  assign link[0].valid = s_tvalid && en;
  assign link[0].px    = s_tdata[9:0];
  assign link[0].py    = s_tdata[19:10];
  assign link[0].count = 8'd0;

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    dcm_cell #(.K(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .geom     (geom),
      .item_in  (link[i]),
      .item_out (link[i+1])
    );
  end

  // ---- result buffer
  dcm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (link[SAMPLE_COUNT].valid && en),
    .push_data (link[SAMPLE_COUNT].count),
    .room      (en),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // ---- checks
  // input back-pressure only comes from a buffer holding results
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("chain stalled with empty result buffer");

  // a finished count never exceeds the number of samples
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    link[SAMPLE_COUNT].valid |-> (link[SAMPLE_COUNT].count <= 8'(SAMPLE_COUNT)))
    else $error("coverage count above sample count");

  // ring inner radius stays inside the outer radius for a nonzero mask
  a_ring_radii: assert property (@(posedge clk) disable iff (rst)
    (size_c != 11'd0) |-> (r_in <= r_out))
    else $error("inner radius beyond outer radius");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes on the cfg channel
  localparam logic [7:0] REG_MASK_SIZE  = 8'd0;
  localparam logic [7:0] REG_SHAPE_MODE = 8'd1;
  // indexes past the register list, dropped by the block
  localparam logic [7:0] REG_NONE_LO    = 8'd2;
  localparam logic [7:0] REG_NONE_HI    = 8'd255;

  localparam logic       SHAPE_DISK = 1'b0;
  localparam logic       SHAPE_RING = 1'b1;

  // geometry of the sample pattern
  localparam int          N_SAMPLES = 255;
  localparam int          SUB_BITS  = 23;
  localparam int          SIZE_CAP  = 1024;
  localparam logic [31:0] R2_STEP_X = 32'd3242174889;
  localparam logic [31:0] R2_STEP_Y = 32'd2447445413;

  localparam int CHAIN_DEPTH     = 3 * N_SAMPLES + 1;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int N_RAND_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 67;

  // Expected coverage per accepted pixel, kept in acceptance order.
  class coverage_scoreboard;
    logic [10:0] mask_size;
    logic        ring_mode;
    logic [7:0]  coverage_q[$];
    int          failures;

    function new();
      mask_size = 11'd16;
      ring_mode = SHAPE_DISK;
      failures  = 0;
    endfunction

    function void set_register(input logic [7:0] idx, input logic [10:0] val);
      if (idx == REG_MASK_SIZE)
        mask_size = val;
      else if (idx == REG_SHAPE_MODE)
        ring_mode = val[0];
    endfunction

    // count of R2 samples of pixel (px, py) that land inside the shape
    function logic [7:0] coverage_of(input logic [9:0] px, input logic [9:0] py);
      logic [10:0]  size;
      logic [32:0]  r_out, r_in, ox, oy, dx, dy;
      logic [31:0]  vx, vy;
      logic [127:0] out_sq, in_sq, dist_sq;
      logic         hit;
      int           hits;
      size   = (mask_size > SIZE_CAP) ? 11'(SIZE_CAP) : mask_size;
      r_out  = 33'(size) << (SUB_BITS - 1);
      // magnitude of the inner radius; only goes negative for a zero- or one-pixel mask
      r_in   = (r_out >= (33'd1 << SUB_BITS)) ? r_out - (33'd1 << SUB_BITS)
                                              : (33'd1 << SUB_BITS) - r_out;
      out_sq = 128'(r_out) * 128'(r_out);
      in_sq  = 128'(r_in) * 128'(r_in);
      hits   = 0;
      for (int k = 0; k < N_SAMPLES; k++) begin
        vx = 32'(k) * R2_STEP_X;
        vy = 32'(k) * R2_STEP_Y;
        ox = (33'(px) << SUB_BITS) + 33'(vx[31:32-SUB_BITS]);
        oy = (33'(py) << SUB_BITS) + 33'(vy[31:32-SUB_BITS]);
        dx = (ox >= r_out) ? ox - r_out : r_out - ox;
        dy = (oy >= r_out) ? oy - r_out : r_out - oy;
        dist_sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        hit = (dist_sq <= out_sq);
        if (ring_mode)
          hit = hit && (in_sq <= dist_sq);
        if (hit)
          hits++;
      end
      return hits[7:0];
    endfunction

    function void note_pixel(input logic [9:0] px, input logic [9:0] py);
      coverage_q.push_back(coverage_of(px, py));
    endfunction

    function void check_coverage(input logic [7:0] got);
      logic [7:0] want;
      if (coverage_q.size() == 0) begin
        $error("coverage: item with none pending, expected none, actual %0d", got);
        failures++;
        return;
      end
      want = coverage_q.pop_front();
      if (got !== want) begin
        $error("coverage: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction

    function int pending();
      return coverage_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [9:0] pixel_x, [19:10] pixel_y, [23:20] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [7:0] coverage
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [10:0] cfg_data;

  coverage_scoreboard sb = new();

  // per-item idle limits; zero gives back-to-back stretches
  int gap_max   = 0;
  int stall_max = 0;

  always #6 clk = ~clk;

  disk_ring_coverage_mask u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Push one pixel item. tvalid is left high on return so that a
  // zero-gap follower keeps it up without a low/high pair in one step.
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(px, py);
  endtask

  // Stop sending and hold off until every pending coverage has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; block must be idle. Ends in the cycle after the
  // handshake so back-to-back writes never share a step.
  task automatic write_reg(input logic [7:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [10:0] size, input logic mode);
    logic [9:0] junk;
    junk = 10'($urandom);
    drain();
    write_reg(REG_MASK_SIZE, size);
    // upper data bits are don't-care for the mode register
    write_reg(REG_SHAPE_MODE, {junk, mode});
  endtask

  // Pixel picker: mostly inside the mask, a good share on the disk edge
  // where coverage is partial, and some anywhere in the 10-bit range.
  task automatic pick_pixel(input int size, output logic [9:0] px, output logic [9:0] py);
    int  span, roll, a, b;
    real c, off, rr;
    logic [9:0] t;
    span = (size > SIZE_CAP) ? SIZE_CAP : size;
    roll = $urandom_range(0, 99);
    if (span == 0 || roll < 15) begin
      px = 10'($urandom_range(0, 1023));
      py = 10'($urandom_range(0, 1023));
    end else if (span >= 2 && roll < 60) begin
      a   = $urandom_range(0, span - 1);
      c   = span / 2.0;
      off = a + 0.5 - c;
      rr  = c * c - off * off;
      if (rr < 0.0)
        rr = 0.0;
      b = $urandom_range(0, 1) ? $rtoi(c + $sqrt(rr)) : $rtoi(c - $sqrt(rr));
      b = b + $urandom_range(0, 2) - 1;
      if (b < 0)
        b = 0;
      if (b > span - 1)
        b = span - 1;
      px = 10'(a);
      py = 10'(b);
      if ($urandom_range(0, 1)) begin
        t  = px;
        px = py;
        py = t;
      end
    end else begin
      px = 10'($urandom_range(0, span - 1));
      py = 10'($urandom_range(0, span - 1));
    end
  endtask

  // Result side: random stall before each item, then wait for it.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_coverage(m_tdata);
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [10:0] sizes [N_RAND_PHASES];
    logic [9:0]  px, py;
    logic        mode;

    sizes = '{11'd2, 11'd3, 11'd16, 11'd31, 11'd64, 11'd200, 11'd0, 11'd1024,
              11'd2047, 11'd1, 11'd1023, 11'd5};

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset shape: 16 px disk, centre on the corner of pixels 7 and 8
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd8, 10'd8);
    send_pixel(10'd7, 10'd8);
    send_pixel(10'd15, 10'd15);
    send_pixel(10'd0, 10'd8);
    send_pixel(10'd1023, 10'd1023);     // far outside the mask
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'h155, 10'h2AA);       // alternating bit patterns
    send_pixel(10'h2AA, 10'h155);

    // dropped register indexes must leave the shape alone
    drain();
    write_reg(REG_NONE_LO, 11'd3);
    write_reg(REG_NONE_HI, 11'h7FF);
    send_pixel(10'd8, 10'd7);

    set_shape(11'd16, SHAPE_RING);
    send_pixel(10'd0, 10'd8);
    send_pixel(10'd8, 10'd0);
    send_pixel(10'd8, 10'd8);
    send_pixel(10'd2, 10'd3);

    // zero size: disk keeps only samples exactly on the centre
    set_shape(11'd0, SHAPE_DISK);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    set_shape(11'd0, SHAPE_RING);
    send_pixel(10'd0, 10'd0);

    // one-pixel ring: inner radius goes negative, magnitude used
    set_shape(11'd1, SHAPE_RING);
    send_pixel(10'd0, 10'd0);
    set_shape(11'd1, SHAPE_DISK);
    send_pixel(10'd0, 10'd0);

    // oversized mask clamps to the largest size
    set_shape(11'd2047, SHAPE_DISK);
    send_pixel(10'd511, 10'd511);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd0);
    set_shape(11'd1024, SHAPE_RING);
    send_pixel(10'd1023, 10'd512);

    // --- random phases; each config change waits for an empty pipe ---
    for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
      mode = ($urandom_range(0, 1) != 0);
      set_shape(sizes[ph], mode);
      gap_max   = (ph % 3 == 0) ? 0 : 12;
      stall_max = (ph % 4 == 1) ? 0 : 12;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick_pixel(int'(sizes[ph]), px, py);
        send_pixel(px, py);
        // hold the sender once mid-phase until the chain has emptied
        if (ph == 4 && i == ITEMS_PER_PHASE / 2)
          drain();
      end
    end

    drain();
    // any stray item out of the chain would show up in this window
    repeat (CHAIN_DEPTH + 16) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
